// ===== design/assert_macros.svh =====
// Assertion macros shared by the spanning tree block.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted (active low).
`define PMST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define PMST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/pmst_pkg.sv =====
// Shared constants and types of the spanning tree block.
// No dependencies; used by pmst_relax_unit and prim_minimum_spanning_tree.
package pmst_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int IDX_W    = 4;   // width of vertex index fields
    localparam int WIN_W    = 16;  // width of weight fields
    localparam int VCOUNT_W = 5;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd5;
    localparam int                  VCOUNT_MIN   = 2;

    // Result of one relax / min-compare step.
    typedef struct packed {
        logic upd;     // edge improves this vertex's key
        logic better;  // new key beats the running minimum
        logic free;    // vertex is still outside the tree
    } t_relax_flags;

endpackage

// ===== design/pmst_weight_ram.sv =====
// Weight matrix storage: one write port, one read port with registered data.
// Depends on nothing.
module pmst_weight_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pmst_relax_unit.sv =====
// Shared compare unit: relaxes one key against an edge weight and compares
// the result with the running minimum. Depends on pmst_pkg.
module pmst_relax_unit #(
    parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic [WEIGHT_BITS:0]   i_key,
    input  logic                   i_in_tree,
    input  logic [WEIGHT_BITS:0]   i_min_key,
    output pmst_pkg::t_relax_flags o_flags,
    output logic [WEIGHT_BITS:0]   o_key_new
);

    logic [WEIGHT_BITS:0] w_ext;
    logic                 upd;

    assign w_ext = {1'b0, i_weight};
    // zero weight means no edge
    assign upd       = (i_weight != '0) && !i_in_tree && (w_ext < i_key);
    assign o_key_new = upd ? w_ext : i_key;

    assign o_flags.upd    = upd;
    assign o_flags.better = !i_in_tree && (o_key_new < i_min_key);
    assign o_flags.free   = !i_in_tree;

endmodule

// ===== design/prim_minimum_spanning_tree.sv =====
// prim_minimum_spanning_tree: Prim spanning tree over a loaded weight matrix.
// Depends on pmst_pkg, pmst_weight_ram, pmst_relax_unit, assert_macros.svh.
//
// Input channel (i_in_valid / o_in_stall): one matrix item per cycle while
// o_in_stall is low, each written to the weight RAM. Entries outside the matrix
// are dropped. Weight 0 means no edge. An item with i_last_entry set starts the
// tree build from vertex 0 over n = clamp(vertex_count, 2, MAX_VERTICES)
// vertices; o_in_stall stays high until the last result has been loaded into
// the output register. Build: an init step, then n rounds, each a pick step,
// n RAM reads through the shared relax/compare unit, a drain and a decide
// step; then a RAM read and an output load for each result.
// Output channel (o_out_valid / i_out_stall): n-1 items, child 1..n-1 in
// order, last_result on child n-1. A stalled result holds; the sequencer
// waits until the output register frees up. Disconnected vertices get
// unreachable set; a new component root reports parent 0 and weight 0.
// Config: i_cfg_we writes vertex_count; write only while idle.
// Reset (synchronous, active low) returns to idle, drops any pending result
// and sets vertex_count to 5. The weight RAM is not cleared.
module prim_minimum_spanning_tree #(
    parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = pmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // matrix items
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pmst_pkg::IDX_W-1:0]     i_row_index,
    input  logic [pmst_pkg::IDX_W-1:0]     i_col_index,
    input  logic [pmst_pkg::WIN_W-1:0]     i_edge_weight,
    input  logic                           i_last_entry,
    // tree edge items
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pmst_pkg::IDX_W-1:0]     o_child_vertex,
    output logic [pmst_pkg::IDX_W-1:0]     o_parent_vertex,
    output logic [pmst_pkg::WIN_W-1:0]     o_tree_weight,
    output logic                           o_unreachable,
    output logic                           o_last_result,
    // config
    input  logic                           i_cfg_we,
    input  logic [pmst_pkg::VCOUNT_W-1:0]  i_cfg_wdata
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = WEIGHT_BITS + 1;
    localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_PICK,
        S_PASS,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    t_state r_state;

    logic [pmst_pkg::VCOUNT_W-1:0] r_vcount;
    logic [NW-1:0]                 r_n;
    logic [NW-1:0]                 r_round;
    logic [NW-1:0]                 r_v;       // RAM read index in a pass
    logic [VW-1:0]                 r_v_d;     // index of the data coming back
    logic                          r_vd_valid;
    logic [NW-1:0]                 r_i;       // result index
    logic [VW-1:0]                 r_u;       // vertex joining the tree
    logic                          r_found;   // r_u came from a finite key

    // per-vertex state
    logic [KW-1:0] r_key    [MAX_VERTICES];
    logic          r_in_tree[MAX_VERTICES];
    logic [VW-1:0] r_parent [MAX_VERTICES];
    logic          r_cut    [MAX_VERTICES];

    // running minimum and first free vertex of the current pass
    logic [KW-1:0] r_min_key;
    logic [VW-1:0] r_min_u;
    logic          r_free_found;
    logic [VW-1:0] r_free_u;

    // output register
    logic                       r_out_valid;
    logic [pmst_pkg::IDX_W-1:0] r_o_child;
    logic [pmst_pkg::IDX_W-1:0] r_o_parent;
    logic [pmst_pkg::WIN_W-1:0] r_o_weight;
    logic                       r_o_unreach;
    logic                       r_o_last;

    // clamped vertex count
    logic [31:0] vc32;
    logic [NW-1:0] n_count;
    always_comb begin
        vc32 = 32'(r_vcount);
        priority if (vc32 < 32'(pmst_pkg::VCOUNT_MIN)) begin
            n_count = NW'(pmst_pkg::VCOUNT_MIN);
        end else if (vc32 > 32'(MAX_VERTICES)) begin
            n_count = NW'(MAX_VERTICES);
        end else begin
            n_count = NW'(r_vcount);
        end
    end

    // input side
    logic in_take;
    logic wr_in_range;
    logic [AW-1:0] wr_addr;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign wr_in_range = (32'(i_row_index) < 32'(MAX_VERTICES)) &&
                         (32'(i_col_index) < 32'(MAX_VERTICES));
    assign wr_addr     = AW'(i_row_index) * AW'(MAX_VERTICES) + AW'(i_col_index);

    // shared array read ports
    logic [VW-1:0] sel_idx;
    logic [VW-1:0] par_rd;
    logic [VW-1:0] cut_idx;
    logic          cut_rd;
    logic [VW-1:0] key_idx;
    logic [KW-1:0] key_rd;
    assign sel_idx = (r_state == S_PICK) ? r_u : r_i[VW-1:0];
    assign par_rd  = r_parent[sel_idx];
    // on a pick the new vertex inherits its parent's component mark
    assign cut_idx = (r_state == S_PICK) ? par_rd : sel_idx;
    assign cut_rd  = r_cut[cut_idx];
    assign key_idx = (r_state == S_PASS) ? r_v_d : r_i[VW-1:0];
    assign key_rd  = r_key[key_idx];

    // weight RAM read: row u during a pass, row i with its parent on output
    logic          pass_issue;
    logic          ram_re;
    logic [VW-1:0] ra_row;
    logic [VW-1:0] ra_col;
    logic [AW-1:0] ram_raddr;
    logic [WEIGHT_BITS-1:0] ram_rdata;
    assign pass_issue = (r_state == S_PASS) && (r_v < r_n);
    assign ram_re     = pass_issue || (r_state == S_OUT_RD);
    assign ra_row     = (r_state == S_PASS) ? r_u : r_i[VW-1:0];
    assign ra_col     = (r_state == S_PASS) ? r_v[VW-1:0] : par_rd;
    assign ram_raddr  = AW'(ra_row) * AW'(MAX_VERTICES) + AW'(ra_col);

    pmst_weight_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (WEIGHT_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_take && wr_in_range),
        .i_waddr (wr_addr),
        .i_wdata (WEIGHT_BITS'(i_edge_weight)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pmst_pkg::t_relax_flags relax;
    logic [KW-1:0]          key_new;

    pmst_relax_unit #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_relax (
        .i_weight  (ram_rdata),
        .i_key     (key_rd),
        .i_in_tree (r_in_tree[r_v_d]),
        .i_min_key (r_min_key),
        .o_flags   (relax),
        .o_key_new (key_new)
    );

    logic out_free;
    logic pass_done;
    logic res_last;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pass_done = !r_vd_valid && (r_v == r_n);
    assign res_last  = (r_i == r_n - NW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vcount    <= pmst_pkg::VCOUNT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            // taken result leaves; S_OUT_LD refills the register itself
            if (!i_out_stall && r_state != S_OUT_LD) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take && i_last_entry) begin
                        r_state <= S_INIT;
                    end
                end

                S_INIT: begin
                    for (int k = 0; k < MAX_VERTICES; k++) begin
                        r_key[k]     <= (k == 0) ? '0 : KEY_INF;
                        r_in_tree[k] <= 1'b0;
                        r_parent[k]  <= '0;
                        r_cut[k]     <= 1'b0;
                    end
                    r_n      <= n_count;
                    r_round  <= '0;
                    r_u      <= '0;
                    r_found  <= 1'b1;
                    r_state  <= S_PICK;
                end

                S_PICK: begin
                    r_in_tree[r_u] <= 1'b1;
                    if (r_found) begin
                        r_cut[r_u] <= cut_rd;
                    end else begin
                        // root of a component not reached from vertex 0
                        r_cut[r_u]    <= 1'b1;
                        r_parent[r_u] <= '0;
                    end
                    r_round      <= r_round + NW'(1);
                    r_v          <= '0;
                    r_vd_valid   <= 1'b0;
                    r_min_key    <= KEY_INF;
                    r_free_found <= 1'b0;
                    r_state      <= S_PASS;
                end

                S_PASS: begin
                    if (pass_issue) begin
                        r_v_d      <= r_v[VW-1:0];
                        r_v        <= r_v + NW'(1);
                        r_vd_valid <= 1'b1;
                    end else begin
                        r_vd_valid <= 1'b0;
                    end
                    if (r_vd_valid) begin
                        if (relax.upd) begin
                            r_key[r_v_d]    <= key_new;
                            r_parent[r_v_d] <= r_u;
                        end
                        // strict compare in index order: lowest index wins ties
                        if (relax.better) begin
                            r_min_key <= key_new;
                            r_min_u   <= r_v_d;
                        end
                        if (relax.free && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_u     <= r_v_d;
                        end
                    end
                    if (pass_done) begin
                        r_found <= (r_min_key != KEY_INF);
                        r_u     <= (r_min_key != KEY_INF) ? r_min_u : r_free_u;
                        if (r_round == r_n) begin
                            r_i     <= NW'(1);
                            r_state <= S_OUT_RD;
                        end else begin
                            r_state <= S_PICK;
                        end
                    end
                end

                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end

                S_OUT_LD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_child   <= pmst_pkg::IDX_W'(r_i);
                        r_o_parent  <= pmst_pkg::IDX_W'(par_rd);
                        r_o_weight  <= (key_rd == KEY_INF) ? '0
                                                           : pmst_pkg::WIN_W'(ram_rdata);
                        r_o_unreach <= cut_rd;
                        r_o_last    <= res_last;
                        r_i         <= r_i + NW'(1);
                        r_state     <= res_last ? S_IDLE : S_OUT_RD;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_child_vertex  = r_o_child;
    assign o_parent_vertex = r_o_parent;
    assign o_tree_weight   = r_o_weight;
    assign o_unreachable   = r_o_unreach;
    assign o_last_result   = r_o_last;

    `include "assert_macros.svh"

    // a picked vertex must still be outside the tree
    `PMST_ASSERT(a_pick_free, i_clk, i_rst_n,
        (r_state == S_PICK) |-> !r_in_tree[r_u], "picked vertex already in tree")
    // results start only after every vertex has joined
    `PMST_ASSERT(a_rounds_done, i_clk, i_rst_n,
        (r_state == S_OUT_RD) |-> (r_round == r_n), "output before all rounds")
    // the final result belongs to vertex n-1
    `PMST_ASSERT(a_last_child, i_clk, i_rst_n,
        (o_out_valid && o_last_result) |->
            (o_child_vertex == pmst_pkg::IDX_W'(r_n - NW'(1))), "last result on wrong vertex")

endmodule
